FILE: rtl/bab_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and split tree helpers of the block and buddy allocator
package bab_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_HEAP_BASE   = 1'b1;

    localparam int MK_CONT = 0;
    localparam int MK_DIV  = 1;

    localparam logic [3:0] T_LDIV  = 4'd1;
    localparam logic [3:0] T_LFULL = 4'd2;
    localparam logic [3:0] T_RDIV  = 4'd4;
    localparam logic [3:0] T_RFULL = 4'd8;

    localparam int TREE_BITS  = 60;
    localparam int ENTRY_BITS = 62;

    typedef struct packed {
        logic [1:0]           marks;
        logic [TREE_BITS-1:0] tree;
    } entry_t;

    typedef struct packed {
        logic                 found;
        logic [3:0]           chunk;
        logic [TREE_BITS-1:0] tree;
    } take_t;

    typedef struct packed {
        logic [2:0]           got;
        logic [TREE_BITS-1:0] tree;
    } release_t;

    // first free chunk at level want, in index order, and the updated tree
    function automatic take_t tree_take(logic [TREE_BITS-1:0] t, logic [2:0] want);
        take_t      r;
        logic       ok;
        logic [3:0] c;
        logic [3:0] f;
        logic [3:0] ch;
        logic [3:0] kk;
        int         pos;
        int         cpos;
        r.found = 1'b0;
        r.chunk = 4'd0;
        r.tree  = t;
        for (int k = 0; k < 16; k++)
        begin
            ok = 1'b1;
            for (int lv = 1; lv <= 4; lv++)
            begin
                c   = 4'(k >> (4 - lv));
                pos = ((1 << (lv - 1)) - 1 + int'(c >> 1)) * 4;
                f   = t[pos +: 4];
                if (lv < int'(want))
                    ok = ok & ~(c[0] ? f[3] : f[1]);
                else if (lv == int'(want))
                    ok = ok & (c[0] ? (f[3:2] == 2'b00) : (f[1:0] == 2'b00));
            end
            if (ok && !r.found)
            begin
                r.found = 1'b1;
                r.chunk = 4'(k);
            end
        end
        kk = r.chunk & (4'hF << (3'd4 - want));
        r.chunk = kk;
        if (r.found)
        begin
            for (int lv = 4; lv >= 1; lv--)
            begin
                if (lv <= int'(want))
                begin
                    c   = kk >> (4 - lv);
                    pos = ((1 << (lv - 1)) - 1 + int'(c >> 1)) * 4;
                    f   = r.tree[pos +: 4];
                    if (lv == int'(want))
                        f = f | (c[0] ? T_RFULL : T_LFULL);
                    else
                    begin
                        cpos = ((1 << lv) - 1 + int'(c)) * 4;
                        ch   = r.tree[cpos +: 4];
                        f    = f | (c[0] ? T_RDIV : T_LDIV);
                        if (ch[1] && ch[3])
                            f = f | (c[0] ? T_RFULL : T_LFULL);
                    end
                    r.tree[pos +: 4] = f;
                end
            end
        end
        return r;
    endfunction

    // release the chunk on the path of co4, merging empty halves upward
    function automatic release_t tree_release(logic [TREE_BITS-1:0] t, logic [3:0] co4);
        release_t   r;
        logic       active;
        logic [3:0] c;
        logic [3:0] f;
        logic       dv;
        int         pos;
        int         cpos;
        r.tree = t;
        r.got  = 3'd4;
        active = 1'b1;
        for (int lv = 1; lv <= 4; lv++)
        begin
            if (active)
            begin
                c   = co4 >> (4 - lv);
                pos = ((1 << (lv - 1)) - 1 + int'(c >> 1)) * 4;
                f   = t[pos +: 4];
                dv  = c[0] ? f[2] : f[0];
                if (!(dv && lv < 4))
                begin
                    r.got  = 3'(lv);
                    active = 1'b0;
                end
            end
        end
        for (int lv = 4; lv >= 1; lv--)
        begin
            if (lv <= int'(r.got))
            begin
                c   = co4 >> (4 - lv);
                pos = ((1 << (lv - 1)) - 1 + int'(c >> 1)) * 4;
                f   = r.tree[pos +: 4];
                if (c[0])
                    f[3] = 1'b0;
                else
                    f[1] = 1'b0;
                if (lv < 4)
                begin
                    cpos = ((1 << lv) - 1 + int'(c)) * 4;
                    if (r.tree[cpos +: 4] == 4'd0)
                    begin
                        if (c[0])
                            f[3:2] = 2'b00;
                        else
                            f[1:0] = 2'b00;
                    end
                end
                r.tree[pos +: 4] = f;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/block_and_buddy_allocator.sv
`timescale 1ns / 1ps
// block and buddy heap allocator: descriptor memory and its sequencer
//
// requests enter on the s_ stream: s_tuser is the command (0 allocate,
// 1 free), s_tdata carries the size and the address. each request gives
// exactly one result transaction on the m_ stream: status, address, freed bytes.
// configuration (block count, heap base) is to be written over cfg_ only
// while idle; the block does not enforce this. block descriptors live in one
// memory with a registered read; every visit to a descriptor is a read state
// followed by a check state, which may also write the descriptor back. a large
// allocate scans up to block_count descriptors, then rewrites the run; a small
// allocate scans until a block holds a fitting chunk; a free walks the
// continued run. after reset the memory is cleared, one descriptor a cycle,
// while s_tready stays low.
// a finished result waits in the output register while the next request
// is taken; the sequencer holds at its end only if that register is still full.
module block_and_buddy_allocator
    import bab_pkg::*;
#(
    parameter int MAX_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // req_size[31:0], address[63:32]
    input  logic        s_tuser,    // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // status[1:0], result_address[33:2], freed_bytes[54:34]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LB = $clog2(BLOCK_BYTES);
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HALF_BLOCK = 32'(BLOCK_BYTES / 2);
    localparam logic [31:0] QUARTER    = 32'(BLOCK_BYTES / 4);
    localparam logic [31:0] EIGHTH     = 32'(BLOCK_BYTES / 8);
    localparam logic [31:0] SIXTEENTH  = 32'(BLOCK_BYTES / 16);
    localparam logic [20:0] BLOCK_INC  = 21'(BLOCK_BYTES);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_BRD  = 4'd3;
    localparam logic [3:0] S_BCHK = 4'd4;
    localparam logic [3:0] S_BWRD = 4'd5;
    localparam logic [3:0] S_BWR  = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCHK = 4'd8;
    localparam logic [3:0] S_FRD  = 4'd9;
    localparam logic [3:0] S_FCHK = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    logic          mem_we;
    logic          mem_re;
    logic [BW-1:0] mem_wa;
    logic [BW-1:0] mem_ra;
    entry_t        mem_wd;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] run_reg, run_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] need_reg, need_next;
    logic [2:0]    want_reg, want_next;
    logic          cmd_reg, cmd_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   addr_reg, addr_next;
    logic [3:0]    co4_reg, co4_next;
    logic [20:0]   freed_reg, freed_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [54:0]   out_data_reg, out_data_next;
    logic [8:0]    count_reg, count_next;
    logic [31:0]   base_reg, base_next;

    logic [IW-1:0] n_eff;
    logic [31:0]   offs;
    logic [63:0]   heap_end;
    take_t         take;
    release_t      rel;
    logic [21:0]   freed_sum;
    logic [20:0]   freed_inc;
    logic [20:0]   freed_sat;

    assign n_eff     = (32'(count_reg) > 32'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : IW'(count_reg);
    assign offs      = addr_reg - base_reg;
    assign heap_end  = 64'(base_reg) + (64'(n_eff) << LB);
    assign take      = tree_take(rd_data_reg.tree, want_reg);
    assign rel       = tree_release(rd_data_reg.tree, co4_reg);
    assign freed_sum = 22'(freed_reg) + 22'(freed_inc);
    assign freed_sat = freed_sum[21] ? 21'h1FFFFF : freed_sum[20:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        want_next       = want_reg;
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        co4_next        = co4_reg;
        freed_next      = freed_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_data_next   = out_data_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = idx_reg[BW-1:0];
        mem_ra          = idx_reg[BW-1:0];
        mem_wd          = '0;
        freed_inc       = BLOCK_INC;

        if (cfg_valid)
        begin
            if (cfg_index == REG_BLOCK_COUNT)
                count_next = cfg_data[8:0];
            else
                base_next = cfg_data;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (32'(idx_reg) == 32'(MAX_BLOCKS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    size_next  = s_tdata[31:0];
                    addr_next  = s_tdata[63:32];
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_status_next = STATUS_OK;
                res_addr_next   = '0;
                freed_next      = '0;
                idx_next        = '0;
                run_next        = '0;
                need_next       = IW'(size_reg >> LB) + IW'(|size_reg[LB-1:0]);
                co4_next        = offs[LB-1:LB-4];
                if (size_reg > QUARTER)
                    want_next = 3'd1;
                else if (size_reg > EIGHTH)
                    want_next = 3'd2;
                else if (size_reg > SIXTEENTH)
                    want_next = 3'd3;
                else
                    want_next = 3'd4;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (64'(size_reg) > (64'(n_eff) << LB))
                    begin
                        res_status_next = STATUS_NOSPACE;
                        state_next      = S_DONE;
                    end
                    else if (size_reg > HALF_BLOCK)
                        state_next = S_BRD;
                    else
                        state_next = S_SRD;
                end
                else
                begin
                    if (addr_reg < base_reg || 64'(addr_reg) >= heap_end)
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = IW'(offs >> LB);
                        state_next = S_FRD;
                    end
                end
            end
            S_BRD:
            begin
                if (run_reg >= need_reg)
                begin
                    idx_next   = start_reg;
                    run_next   = '0;
                    state_next = S_BWRD;
                end
                else if (idx_reg == n_eff)
                begin
                    res_status_next = STATUS_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if (rd_data_reg.tree[3] == 1'b0 && rd_data_reg.tree[1] == 1'b0 &&
                    !rd_data_reg.marks[MK_DIV])
                begin
                    if (run_reg == '0)
                        start_next = idx_reg;
                    run_next = run_reg + 1'b1;
                end
                else
                    run_next = '0;
                idx_next   = idx_reg + 1'b1;
                state_next = S_BRD;
            end
            S_BWRD:
            begin
                mem_re     = 1'b1;
                state_next = S_BWR;
            end
            S_BWR:
            begin
                mem_we                = 1'b1;
                mem_wd.tree           = rd_data_reg.tree;
                mem_wd.tree[3:0]      = T_LFULL | T_RFULL;
                mem_wd.marks          = '0;
                mem_wd.marks[MK_CONT] = (run_reg + 1'b1) < need_reg;
                run_next              = run_reg + 1'b1;
                idx_next              = idx_reg + 1'b1;
                if ((run_reg + 1'b1) == need_reg)
                begin
                    res_addr_next = base_reg + (32'(start_reg) << LB);
                    state_next    = S_DONE;
                end
                else
                    state_next = S_BWRD;
            end
            S_SRD:
            begin
                if (idx_reg == n_eff)
                begin
                    res_status_next = STATUS_NOSPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (take.found)
                begin
                    mem_we               = 1'b1;
                    mem_wd.tree          = take.tree;
                    mem_wd.marks         = rd_data_reg.marks;
                    mem_wd.marks[MK_DIV] = 1'b1;
                    res_addr_next        = base_reg + (32'(idx_reg) << LB)
                                         + (32'(take.chunk) << (LB - 4));
                    state_next           = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_FRD:
            begin
                mem_re     = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                mem_we = 1'b1;
                if ((32'(idx_reg) + 32'd1) < 32'(MAX_BLOCKS) && rd_data_reg.marks[MK_CONT])
                begin
                    freed_next = freed_sat;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FRD;
                end
                else if (rd_data_reg.marks[MK_DIV])
                begin
                    mem_wd.tree          = rel.tree;
                    mem_wd.marks         = rd_data_reg.marks;
                    mem_wd.marks[MK_DIV] = (rel.tree[3:0] != 4'd0);
                    freed_inc            = BLOCK_INC >> rel.got;
                    freed_next           = freed_sat;
                    state_next           = S_DONE;
                end
                else
                begin
                    freed_next = freed_sat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {freed_reg, res_addr_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        start_reg      <= start_next;
        need_reg       <= need_next;
        want_reg       <= want_next;
        cmd_reg        <= cmd_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        co4_reg        <= co4_next;
        freed_reg      <= freed_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("request accepted during clearing pass");

    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("descriptor read and write in the same cycle");

    a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !m_tready) |=> (state_reg == S_DONE))
        else $error("result dropped while output register full");
`endif

endmodule
